### rtl/core/fba_pkg.sv
package fba_pkg;

	localparam int MAX_FRAMES    = 4096;
	localparam int BITS_PER_WORD = 32;
	localparam int WORDS         = MAX_FRAMES / BITS_PER_WORD;
	localparam int WORD_AW       = $clog2(WORDS);
	localparam int BIT_AW        = $clog2(BITS_PER_WORD);
	localparam int FRAME_W       = $clog2(MAX_FRAMES);
	localparam int COUNT_W       = FRAME_W + 1;
	localparam int SLICE         = 8;
	localparam int SLICE_AW      = $clog2(SLICE);
	localparam int SUB_W         = BIT_AW - SLICE_AW;

	localparam logic [COUNT_W-1:0] TOTAL_RESET = COUNT_W'(MAX_FRAMES);

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_RESERVE = 2'd2;
	localparam logic [1:0] OP_CHECK   = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_BAD     = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FRAME_W-1:0] frame_index;
		logic [COUNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FRAME_W-1:0] result_frame;
		logic               frame_used;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RMW,
		ST_CHECK,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/frame_bitmap_allocator.sv
// Physical frame allocator over a 128 x 32 bit bitmap memory with one registered read port
// and one write port; a set of per-word valid flags makes the whole bitmap read as free
// right after reset, so there is no clearing pass. One request is handled at a time.
// Allocate scans the bitmap one slice of eight frames per cycle from frame 0 up to the first
// fitting run, so a scan that finds no run covers ceil(limit / 8) slices (at least one); the
// run is then marked with one read-modify-write per word it touches. Every request ends in a
// state that loads the response register: a request with a bad count or range goes there
// straight from the request transfer without writing the memory, a check after a state that
// samples the read word, a free or reserve after one read-modify-write per word touched, and
// an allocate after its scan and, if a run fits, one read-modify-write per word marked. The
// loading state waits while the previous response still waits for its transfer. The response
// register frees the request side, so the next request is taken in the cycle after the load
// even while the previous response still waits.
module frame_bitmap_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  fba_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output fba_pkg::rsp_t                    rsp,
	input  logic                             cfg_we,
	input  logic [fba_pkg::COUNT_W-1:0]      cfg_wdata
);

	localparam int AW = fba_pkg::WORD_AW;
	localparam int FW = fba_pkg::FRAME_W;
	localparam int CW = fba_pkg::COUNT_W;
	localparam int BW = fba_pkg::BITS_PER_WORD;

	fba_pkg::state_t state_q, state_d;

	logic [CW-1:0] total_q;
	logic [CW-1:0] lim;

	// Bitmap memory and its per-word valid flags.
	logic [BW-1:0] mem [fba_pkg::WORDS];
	logic [fba_pkg::WORDS-1:0] vld_q;
	logic [BW-1:0] rdata_q;
	logic          rvld_q;
	logic [BW-1:0] word;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [BW-1:0] wr_data;

	logic              accept;
	logic              emit;
	logic [1:0]        op_q;
	logic [FW-1:0]     start_q;
	logic [FW-1:0]     last_q;
	logic [CW-1:0]     cnt_q;
	logic              set_q;
	logic [AW-1:0]     cur_w_q;
	logic [AW-1:0]     w_q;
	logic [fba_pkg::SUB_W-1:0] sub_q;
	logic [CW-1:0]     run_q;
	fba_pkg::rsp_t     res_q;
	fba_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	logic          req_bad_range;
	logic          req_bad;
	logic [CW:0]   req_end;
	logic [FW-1:0] req_last;

	logic [FW-1:0] f0;
	logic [CW-1:0] run_c;
	logic          hit;
	logic [FW-1:0] hit_f;
	logic [FW-1:0] rframe;
	logic          scan_end;
	logic [AW-1:0] last_w;
	logic [fba_pkg::BIT_AW-1:0] lo_bit;
	logic [fba_pkg::BIT_AW-1:0] hi_bit;
	logic [BW-1:0] mask;

	assign lim = (total_q > CW'(fba_pkg::MAX_FRAMES)) ? CW'(fba_pkg::MAX_FRAMES) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= fba_pkg::TOTAL_RESET;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	assign accept = req_valid && req_ready;

	assign req_end       = {1'b0, 1'b0, req.frame_index} + {1'b0, req.count};
	assign req_bad_range = (req.count == '0) || (req_end > {1'b0, lim});
	assign req_last      = FW'(req.frame_index + req.count[FW-1:0] - FW'(1));

	// A request that is answered with a bad status without writing the memory.
	always_comb begin
		case (req.operation) inside
			fba_pkg::OP_ALLOC: begin
				req_bad = (req.count == '0);
			end
			fba_pkg::OP_FREE, fba_pkg::OP_RESERVE: begin
				req_bad = req_bad_range;
			end
			default: begin
				req_bad = ({1'b0, req.frame_index} >= lim);
			end
		endcase
	end

	// Memory ports.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[cur_w_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[cur_w_q] <= 1'b1;
			end
		end
	end

	// A word that was never written holds only free frames.
	assign word = rvld_q ? rdata_q : '0;

	// Allocation scan over one slice of eight frames of the current word.
	always_comb begin
		logic [CW-1:0] f;
		logic          free;
		f0    = {w_q, sub_q, fba_pkg::SLICE_AW'(0)};
		run_c = run_q;
		hit   = 1'b0;
		hit_f = '0;
		for (int j = 0; j < fba_pkg::SLICE; j++) begin
			f     = {1'b0, f0} + CW'(j);
			free  = !word[{sub_q, fba_pkg::SLICE_AW'(j)}] && (f < lim);
			run_c = free ? CW'(run_c + CW'(1)) : '0;
			if (!hit && run_c == cnt_q) begin
				hit   = 1'b1;
				hit_f = f[FW-1:0];
			end
		end
		rframe   = FW'(hit_f - cnt_q[FW-1:0] + FW'(1));
		scan_end = ({1'b0, f0} + CW'(fba_pkg::SLICE)) >= lim;
	end

	// Range mask for the word under read-modify-write.
	always_comb begin
		last_w = last_q[FW-1 -: AW];
		lo_bit = (cur_w_q == start_q[FW-1 -: AW]) ? start_q[fba_pkg::BIT_AW-1:0] : '0;
		hi_bit = (cur_w_q == last_w) ? last_q[fba_pkg::BIT_AW-1:0] : '1;
		for (int i = 0; i < BW; i++) begin
			mask[i] = (fba_pkg::BIT_AW'(i) >= lo_bit) && (fba_pkg::BIT_AW'(i) <= hi_bit);
		end
		wr_data = set_q ? (word | mask) : (word & ~mask);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fba_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_bad) begin
						state_d = fba_pkg::ST_EMIT;
					end else if (req.operation == fba_pkg::OP_ALLOC) begin
						state_d = fba_pkg::ST_SCAN;
					end else if (req.operation == fba_pkg::OP_CHECK) begin
						state_d = fba_pkg::ST_CHECK;
					end else begin
						state_d = fba_pkg::ST_RMW;
					end
				end
			end
			fba_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = fba_pkg::ST_RMW;
				end else if (scan_end) begin
					state_d = fba_pkg::ST_EMIT;
				end
			end
			fba_pkg::ST_RMW: begin
				if (cur_w_q == last_w) begin
					state_d = fba_pkg::ST_EMIT;
				end
			end
			fba_pkg::ST_CHECK: begin
				state_d = fba_pkg::ST_EMIT;
			end
			fba_pkg::ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fba_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			fba_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				rd_en     = accept;
				rd_addr   = (req.operation == fba_pkg::OP_ALLOC) ? '0 : req.frame_index[FW-1 -: AW];
			end
			fba_pkg::ST_SCAN: begin
				// The next word is fetched while the last slice of this one is scanned.
				rd_en   = hit || (sub_q == '1);
				rd_addr = hit ? rframe[FW-1 -: AW] : AW'(w_q + AW'(1));
			end
			fba_pkg::ST_RMW: begin
				wr_en   = 1'b1;
				rd_en   = 1'b1;
				rd_addr = AW'(cur_w_q + AW'(1));
			end
			fba_pkg::ST_CHECK: begin
			end
			fba_pkg::ST_EMIT: begin
				emit = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request context and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			start_q <= req.frame_index;
			last_q  <= req_last;
			cnt_q   <= req.count;
			set_q   <= (req.operation == fba_pkg::OP_RESERVE);
			cur_w_q <= req.frame_index[FW-1 -: AW];
			w_q     <= '0;
			sub_q   <= '0;
			run_q   <= '0;
			res_q.status       <= req_bad ? fba_pkg::STAT_BAD : fba_pkg::STAT_OK;
			res_q.result_frame <= '0;
			res_q.frame_used   <= 1'b0;
		end else begin
			case (state_q)
				fba_pkg::ST_SCAN: begin
					if (hit) begin
						res_q.result_frame <= rframe;
						start_q <= rframe;
						last_q  <= hit_f;
						cur_w_q <= rframe[FW-1 -: AW];
						set_q   <= 1'b1;
					end else if (scan_end) begin
						res_q.status <= fba_pkg::STAT_NOSPACE;
					end else begin
						run_q <= run_c;
						sub_q <= fba_pkg::SUB_W'(sub_q + fba_pkg::SUB_W'(1));
						if (sub_q == '1) begin
							w_q <= AW'(w_q + AW'(1));
						end
					end
				end
				fba_pkg::ST_RMW: begin
					cur_w_q <= AW'(cur_w_q + AW'(1));
				end
				fba_pkg::ST_CHECK: begin
					if (op_q == fba_pkg::OP_CHECK) begin
						res_q.frame_used <= word[start_q[fba_pkg::BIT_AW-1:0]];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Response register: holds a finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/fba_checker.sv
module fba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input fba_pkg::rsp_t               rsp
);

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == fba_pkg::STAT_OK || rsp.status == fba_pkg::STAT_NOSPACE ||
			rsp.status == fba_pkg::STAT_BAD))
		else $error("undefined status code");

	// Failed requests report neither a frame nor a used bit.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != fba_pkg::STAT_OK |-> rsp.result_frame == '0 && !rsp.frame_used)
		else $error("error response carries data");

	// Only a check reports a used bit, and a check never carries a frame number.
	a_used_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_used |-> rsp.result_frame == '0)
		else $error("used bit together with a frame number");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

### bench/tb_frame_bitmap_allocator.sv
module tb_frame_bitmap_allocator;

	localparam int QUIET_LIMIT = 10000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	fba_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	fba_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [fba_pkg::COUNT_W-1:0] cfg_wdata = '0;

	// Shadow copy of the allocator: one bit per frame plus the frame total.
	logic [fba_pkg::MAX_FRAMES-1:0] frame_map = '0;
	logic [fba_pkg::COUNT_W-1:0] managed_frames = fba_pkg::TOTAL_RESET;
	fba_pkg::rsp_t replies_due[$];
	int unsigned live_run_start[$];
	int unsigned live_run_len[$];

	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	frame_bitmap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int unsigned frame_limit_now();
		int unsigned total;
		total = 32'(managed_frames);
		return (total > fba_pkg::MAX_FRAMES) ? fba_pkg::MAX_FRAMES : total;
	endfunction

	// Applies one request to the shadow bitmap and returns the reply it must produce.
	function automatic fba_pkg::rsp_t apply_frame_request(fba_pkg::req_t r);
		fba_pkg::rsp_t o;
		int unsigned lim, cnt, start, run, first, f;
		bit found;
		o = '0;
		o.status = fba_pkg::STAT_OK;
		lim = frame_limit_now();
		cnt = 32'(r.count);
		start = 32'(r.frame_index);
		first = 0;
		found = 1'b0;
		case (r.operation) inside
			fba_pkg::OP_ALLOC: begin
				if (cnt == 0) begin
					o.status = fba_pkg::STAT_BAD;
				end else begin
					run = 0;
					for (f = 0; f < lim && !found; f++) begin
						run = frame_map[f] ? 0 : run + 1;
						if (run == cnt) begin
							found = 1'b1;
							first = f + 1 - cnt;
						end
					end
					if (found) begin
						for (f = first; f < first + cnt; f++)
							frame_map[f] = 1'b1;
						o.result_frame = fba_pkg::FRAME_W'(first);
						live_run_start.push_back(first);
						live_run_len.push_back(cnt);
					end else begin
						o.status = fba_pkg::STAT_NOSPACE;
					end
				end
			end
			fba_pkg::OP_FREE, fba_pkg::OP_RESERVE: begin
				if (cnt == 0 || start + cnt > lim) begin
					o.status = fba_pkg::STAT_BAD;
				end else begin
					for (f = start; f < start + cnt; f++)
						frame_map[f] = (r.operation == fba_pkg::OP_RESERVE);
				end
			end
			default: begin
				if (start >= lim)
					o.status = fba_pkg::STAT_BAD;
				else
					o.frame_used = frame_map[start];
			end
		endcase
		return o;
	endfunction

	function automatic fba_pkg::req_t frame_req(logic [1:0] op, int unsigned idx,
			int unsigned cnt);
		fba_pkg::req_t r;
		r.operation = op;
		r.frame_index = fba_pkg::FRAME_W'(idx);
		r.count = fba_pkg::COUNT_W'(cnt);
		return r;
	endfunction

	// Mostly well-formed traffic: allocations, frees of runs handed out earlier, reserves
	// and checks inside the limit, with some out-of-range and zero-count noise.
	function automatic fba_pkg::req_t random_frame_request();
		fba_pkg::req_t r;
		int unsigned lim, roll, k;
		lim = frame_limit_now();
		roll = $urandom_range(99);
		r.operation = fba_pkg::OP_CHECK;
		r.frame_index = fba_pkg::FRAME_W'($urandom_range(fba_pkg::MAX_FRAMES - 1));
		r.count = fba_pkg::COUNT_W'($urandom_range(1, 48));
		if (roll < 35) begin
			r.operation = fba_pkg::OP_ALLOC;
			if ($urandom_range(19) == 0)
				r.count = fba_pkg::COUNT_W'($urandom_range(8191));
			else if ($urandom_range(9) == 0)
				r.count = fba_pkg::COUNT_W'($urandom_range(1, lim + 1));
		end else if (roll < 55 && live_run_start.size() != 0) begin
			k = $urandom_range(live_run_start.size() - 1);
			r.operation = fba_pkg::OP_FREE;
			r.frame_index = fba_pkg::FRAME_W'(live_run_start[k]);
			r.count = fba_pkg::COUNT_W'(live_run_len[k]);
			live_run_start.delete(k);
			live_run_len.delete(k);
		end else if (roll < 75) begin
			r.operation = (roll < 68) ? fba_pkg::OP_FREE : fba_pkg::OP_RESERVE;
			if (lim != 0 && $urandom_range(9) != 0) begin
				r.frame_index = fba_pkg::FRAME_W'($urandom_range(lim - 1));
				r.count = fba_pkg::COUNT_W'($urandom_range(1, 64));
			end else begin
				r.count = fba_pkg::COUNT_W'($urandom_range(8191));
			end
		end else if (lim != 0 && $urandom_range(9) != 0) begin
			r.frame_index = fba_pkg::FRAME_W'($urandom_range(lim - 1));
		end
		return r;
	endfunction

	// Leaves valid high after the transfer; the caller either sends again in the same
	// step or ends the burst with end_burst.
	task automatic send_request(input fba_pkg::req_t r);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		replies_due.push_back(apply_frame_request(r));
	endtask

	task automatic end_burst();
		req_valid <= 1'b0;
	endtask

	task automatic wait_replies();
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_frame_total(input int value);
		wait_replies();
		cfg_we <= 1'b1;
		cfg_wdata <= fba_pkg::COUNT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		managed_frames = fba_pkg::COUNT_W'(value);
	endtask

	task automatic test_directed();
		send_request(frame_req(fba_pkg::OP_CHECK, 0, 0));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 0));
		send_request(frame_req(fba_pkg::OP_FREE, 5, 0));
		send_request(frame_req(fba_pkg::OP_RESERVE, 5, 0));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 1));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 31));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 33));
		send_request(frame_req(fba_pkg::OP_CHECK, 64, 0));
		send_request(frame_req(fba_pkg::OP_CHECK, 65, 0));
		send_request(frame_req(fba_pkg::OP_RESERVE, 4095, 1));
		send_request(frame_req(fba_pkg::OP_CHECK, 4095, 0));
		send_request(frame_req(fba_pkg::OP_RESERVE, 4095, 2));
		send_request(frame_req(fba_pkg::OP_FREE, 10, 5));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 3));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 4097));
		send_request(frame_req(fba_pkg::OP_FREE, 0, 4096));
		send_request(frame_req(fba_pkg::OP_RESERVE, 0, 4096));
		send_request(frame_req(fba_pkg::OP_CHECK, 2048, 0));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 1));
		send_request(frame_req(fba_pkg::OP_FREE, 4095, 8191));
		send_request(frame_req(fba_pkg::OP_FREE, 0, 4096));
		send_request(frame_req(fba_pkg::OP_ALLOC, 4095, 4096));
		// Freeing a hole smaller than the request must not satisfy it.
		send_request(frame_req(fba_pkg::OP_FREE, 100, 50));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 60));
		send_request(frame_req(fba_pkg::OP_FREE, 0, 4096));
		end_burst();
	endtask

	task automatic test_register_extremes();
		set_frame_total(1);
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 1));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 1));
		send_request(frame_req(fba_pkg::OP_CHECK, 1, 0));
		send_request(frame_req(fba_pkg::OP_CHECK, 0, 0));
		send_request(frame_req(fba_pkg::OP_RESERVE, 0, 2));
		send_request(frame_req(fba_pkg::OP_FREE, 0, 1));
		end_burst();
		set_frame_total(0);
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 1));
		send_request(frame_req(fba_pkg::OP_CHECK, 0, 0));
		send_request(frame_req(fba_pkg::OP_FREE, 0, 1));
		end_burst();
		set_frame_total(8191);
		send_request(frame_req(fba_pkg::OP_CHECK, 4095, 0));
		send_request(frame_req(fba_pkg::OP_ALLOC, 0, 4096));
		send_request(frame_req(fba_pkg::OP_FREE, 0, 4096));
		end_burst();
	endtask

	task automatic test_random_phase(input int total, input int gap, input int stall,
			input int items);
		int i;
		set_frame_total(total);
		send_gap_pct = gap;
		stall_pct = stall;
		for (i = 0; i < items; i++)
			send_request(random_frame_request());
		end_burst();
	endtask

	// The receiver holds off long enough for the block to fill and refuse requests.
	task automatic test_backpressure();
		int i;
		wait_replies();
		send_gap_pct = 0;
		stall_pct = 0;
		hold_requests <= hold_requests + 1;
		for (i = 0; i < 30; i++)
			send_request(random_frame_request());
		end_burst();
		wait_replies();
	endtask

	always @(posedge clk) begin : receiver
		int holds_served;
		int hold_left;
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : reply_check
		fba_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (replies_due.size() == 0) begin
				$error("reply transfer with nothing outstanding: %p", rsp);
				error_count++;
			end else begin
				want = replies_due.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					error_count++;
				end
				if (rsp.result_frame !== want.result_frame) begin
					$error("result_frame: expected %0d, got %0d",
						want.result_frame, rsp.result_frame);
					error_count++;
				end
				if (rsp.frame_used !== want.frame_used) begin
					$error("frame_used: expected %0d, got %0d",
						want.frame_used, rsp.frame_used);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("** frame_bitmap_allocator: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_phase(4096, 0, 0, 100);
		test_random_phase(300, 48, 0, 150);
		test_backpressure();
		test_random_phase(8191, 0, 48, 150);
		test_random_phase(97, 12, 12, 120);
		test_random_phase(1, 48, 48, 40);
		test_random_phase(0, 0, 0, 20);
		wait_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** frame_bitmap_allocator: PASSED **");
		else
			$display("** frame_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule
